// ----- design/atb_pkg.sv -----
package atb_pkg;

  localparam int MAX_ENTRIES_DEF    = 64;
  localparam int WEIGHT_BITS_DEF    = 32;
  localparam int PROB_FRAC_BITS_DEF = 16;

  localparam int IN_WEIGHT_W = 32;
  localparam int IDX_OUT_W   = 6;
  localparam int PROB_OUT_W  = 17;

  // Job descriptor widths cover the widest legal configuration.
  localparam int JOB_CNT_W = 7;
  localparam int JOB_TOT_W = IN_WEIGHT_W + JOB_CNT_W;

  typedef struct packed {
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last_weight;
  } atb_in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  entry_index;
    logic [PROB_OUT_W-1:0] keep_prob;
    logic [IDX_OUT_W-1:0]  alias_index;
    logic                  last_entry;
    logic                  overflowed;
    logic                  zero_total;
  } atb_out_t;

  typedef struct packed {
    logic [JOB_CNT_W-1:0] n;
    logic [JOB_TOT_W-1:0] tot;
    logic                 ovf;
  } atb_job_t;

endpackage

// ----- design/alias_table_builder_unit.sv -----
// Vose alias table builder. Weights stream in one word per cycle (stall is
// raised only while a table is being built or emitted); the word flagged
// last_weight closes the table. Up to MAX_ENTRIES weights are stored, extra
// weights are dropped and reported through the overflowed flag. Build then
// scales and classifies each entry, pairs small with large entries and
// gives each entry left on a stack a full keep probability. Emission produces
// one word per entry in index order: a saturated entry is output directly,
// otherwise its quotient comes from a one-bit-per-cycle divider. The next
// table's weights are taken as soon as the last entry has been emitted.
module alias_table_builder_unit #(
  parameter int MAX_ENTRIES    = atb_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS    = atb_pkg::WEIGHT_BITS_DEF,
  parameter int PROB_FRAC_BITS = atb_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  atb_pkg::atb_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output atb_pkg::atb_out_t out_word_o
);
  import atb_pkg::*;

  // Weights wider than the input word are clipped to the word.
  localparam int W_W   = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int TOT_W = W_W + CNT_W;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [W_W-1:0]   wr_data;
  logic             push, full, pop, job_valid, done;
  atb_job_t         job_in, job_out;

  // Front: store weights, accumulate the total, hand off a job per table.
  atb_front #(
    .MAX_ENTRIES(MAX_ENTRIES), .W_W(W_W), .CNT_W(CNT_W), .TOT_W(TOT_W),
    .IDX_W(IDX_W)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .job_push_o(push), .job_o(job_in), .job_full_i(full), .done_i(done)
  );

  // Job queue decouples the loader from the builder.
  atb_job_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(full),
    .pop_i(pop), .valid_o(job_valid), .job_o(job_out)
  );

  // Back: scale, pair, drain and emit.
  atb_back #(
    .MAX_ENTRIES(MAX_ENTRIES), .PROB_FRAC_BITS(PROB_FRAC_BITS), .W_W(W_W),
    .CNT_W(CNT_W), .TOT_W(TOT_W), .IDX_W(IDX_W)
  ) u_back (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .job_valid_i(job_valid), .job_i(job_out), .job_pop_o(pop), .done_o(done),
    .out_valid_o, .out_stall_i, .out_word_o
  );

endmodule

// ----- design/atb_job_fifo.sv -----
module atb_job_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  atb_pkg::atb_job_t job_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output atb_pkg::atb_job_t job_o
);
  import atb_pkg::*;

  atb_job_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- design/atb_front.sv -----
module atb_front #(
  parameter int MAX_ENTRIES = atb_pkg::MAX_ENTRIES_DEF,
  parameter int W_W         = 32,
  parameter int CNT_W       = 7,
  parameter int TOT_W       = 39,
  parameter int IDX_W       = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  atb_pkg::atb_in_t  in_word_i,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [W_W-1:0]    wr_data_o,
  output logic              job_push_o,
  output atb_pkg::atb_job_t job_o,
  input  logic              job_full_i,
  input  logic              done_i
);
  import atb_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic             ovf_q, ovf_d;
  logic             hold_q;
  logic             accept, has_room;
  logic [W_W-1:0]   w;

  assign in_stall_o = hold_q | job_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign w          = W_W'(in_word_i.weight);
  assign has_room   = (count_q < CNT_W'(MAX_ENTRIES));

  assign wr_en_o   = accept & has_room;
  assign wr_addr_o = count_q[IDX_W-1:0];
  assign wr_data_o = w;

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    if (has_room) begin
      count_d = count_q + CNT_W'(1);
      total_d = total_q + TOT_W'(w);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign job_push_o = accept & in_word_i.last_weight;
  assign job_o.n    = JOB_CNT_W'(count_d);
  assign job_o.tot  = JOB_TOT_W'(total_d);
  assign job_o.ovf  = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      hold_q  <= 1'b0;
    end else begin
      if (accept) begin
        if (in_word_i.last_weight) begin
          count_q <= '0;
          total_q <= '0;
          ovf_q   <= 1'b0;
          hold_q  <= 1'b1;
        end else begin
          count_q <= count_d;
          total_q <= total_d;
          ovf_q   <= ovf_d;
        end
      end else if (done_i) begin
        hold_q <= 1'b0;
      end
    end
  end

endmodule

// ----- design/atb_back.sv -----
module atb_back #(
  parameter int MAX_ENTRIES    = atb_pkg::MAX_ENTRIES_DEF,
  parameter int PROB_FRAC_BITS = atb_pkg::PROB_FRAC_BITS_DEF,
  parameter int W_W            = 32,
  parameter int CNT_W          = 7,
  parameter int TOT_W          = 39,
  parameter int IDX_W          = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [W_W-1:0]    wr_data_i,
  input  logic              job_valid_i,
  input  atb_pkg::atb_job_t job_i,
  output logic              job_pop_o,
  output logic              done_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output atb_pkg::atb_out_t out_word_o
);
  import atb_pkg::*;

  localparam int F    = PROB_FRAC_BITS;
  localparam int BC_W = $clog2(F + 1);

  typedef enum logic [3:0] {
    IDLE, INIT_RD, INIT_MUL, INIT_WR, PAIR_POP, PAIR_RD, PAIR_UPD, DRAIN,
    EMIT_RD, EMIT_CHK, EMIT_DIV, EMIT_OUT
  } state_e;

  logic [W_W-1:0]   wmem [MAX_ENTRIES];
  logic [TOT_W-1:0] pmem [MAX_ENTRIES];
  logic [IDX_W-1:0] amem [MAX_ENTRIES];
  logic [IDX_W-1:0] smem [MAX_ENTRIES];
  logic [IDX_W-1:0] lmem [MAX_ENTRIES];

  state_e           st_q;
  logic [CNT_W-1:0] n_q, i_q, ns_q, nl_q, ns_m1, nl_m1;
  logic [TOT_W-1:0] tot_q, p_q, rem_q;
  logic             ovf_q, zt;
  logic [IDX_W-1:0] s_q, l_q, alias_q;
  logic [F-1:0]     quo_q;
  logic [F:0]       prob_q;
  logic [BC_W-1:0]  bc_q;
  logic             out_valid_q, is_last, out_free;
  atb_out_t         out_q;

  logic [W_W-1:0]   w_rd_q;
  logic [TOT_W-1:0] pa_rd_q, pb_rd_q;
  logic [IDX_W-1:0] a_rd_q, s_rd_q, l_rd_q, pa_ra, i_idx;

  logic             p_we, a_we, s_we, l_we;
  logic [IDX_W-1:0] p_wa, a_wa, s_wa, l_wa, a_wd, s_wd, l_wd;
  logic [TOT_W-1:0] p_wd, need, newp;
  logic [TOT_W:0]   r2, r2_sub;

  assign ns_m1   = ns_q - CNT_W'(1);
  assign nl_m1   = nl_q - CNT_W'(1);
  assign i_idx   = i_q[IDX_W-1:0];
  assign zt      = (tot_q == '0);
  assign is_last = ((i_q + CNT_W'(1)) == n_q);
  assign out_free = ~out_valid_q | ~out_stall_i;

  assign need = tot_q - pa_rd_q;
  assign newp = (pb_rd_q >= need) ? pb_rd_q - need : '0;
  assign r2     = {rem_q, 1'b0};
  assign r2_sub = r2 - {1'b0, tot_q};

  assign pa_ra = (st_q == PAIR_RD) ? s_rd_q : i_idx;

  // Memory write ports, steered by state.
  always_comb begin
    p_we = 1'b0; p_wa = i_idx;  p_wd = p_q;
    a_we = 1'b0; a_wa = i_idx;  a_wd = i_idx;
    s_we = 1'b0; s_wa = ns_q[IDX_W-1:0]; s_wd = i_idx;
    l_we = 1'b0; l_wa = nl_q[IDX_W-1:0]; l_wd = i_idx;
    unique case (st_q)
      INIT_WR: begin
        p_we = 1'b1;
        a_we = 1'b1;
        if (!zt) begin
          s_we = (p_q < tot_q);
          l_we = (p_q >= tot_q);
        end
      end
      PAIR_UPD: begin
        a_we = 1'b1; a_wa = s_q; a_wd = l_q;
        p_we = 1'b1; p_wa = l_q; p_wd = newp;
        s_wd = l_q;  l_wd = l_q;
        s_we = (newp < tot_q);
        l_we = (newp >= tot_q);
      end
      DRAIN: begin
        p_we = 1'b1;
        p_wd = tot_q;
        p_wa = (ns_q != '0) ? s_rd_q : l_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) wmem[wr_addr_i] <= wr_data_i;
    w_rd_q <= wmem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pmem[p_wa] <= p_wd;
    pa_rd_q <= pmem[pa_ra];
    pb_rd_q <= pmem[l_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) amem[a_wa] <= a_wd;
    a_rd_q <= amem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_wa] <= s_wd;
    s_rd_q <= smem[ns_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lmem[l_wa] <= l_wd;
    l_rd_q <= lmem[nl_m1[IDX_W-1:0]];
  end

  assign job_pop_o = (st_q == IDLE) & job_valid_i;
  assign done_o    = (st_q == EMIT_OUT) & out_free & is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= IDLE;
      n_q         <= '0;
      tot_q       <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      ns_q        <= '0;
      nl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the output word once taken, unless a new one replaces it below.
      if (out_valid_q && !out_stall_i && st_q != EMIT_OUT) out_valid_q <= 1'b0;
      unique case (st_q)
        IDLE: begin
          if (job_valid_i) begin
            n_q   <= CNT_W'(job_i.n);
            tot_q <= TOT_W'(job_i.tot);
            ovf_q <= job_i.ovf;
            i_q   <= '0;
            ns_q  <= '0;
            nl_q  <= '0;
            st_q  <= INIT_RD;
          end
        end
        INIT_RD:  st_q <= INIT_MUL;
        INIT_MUL: begin
          p_q  <= TOT_W'(w_rd_q) * TOT_W'(n_q);
          st_q <= INIT_WR;
        end
        INIT_WR: begin
          if (s_we) ns_q <= ns_q + CNT_W'(1);
          if (l_we) nl_q <= nl_q + CNT_W'(1);
          if (is_last) begin
            i_q  <= '0;
            st_q <= zt ? EMIT_RD : PAIR_POP;
          end else begin
            i_q  <= i_q + CNT_W'(1);
            st_q <= INIT_RD;
          end
        end
        PAIR_POP: begin
          priority if (ns_q != '0 && nl_q != '0) st_q <= PAIR_RD;
          else if (ns_q != '0 || nl_q != '0) st_q <= DRAIN;
          else st_q <= EMIT_RD;
        end
        PAIR_RD: begin
          s_q  <= s_rd_q;
          l_q  <= l_rd_q;
          ns_q <= ns_m1;
          nl_q <= nl_m1;
          st_q <= PAIR_UPD;
        end
        PAIR_UPD: begin
          if (s_we) ns_q <= ns_q + CNT_W'(1);
          if (l_we) nl_q <= nl_q + CNT_W'(1);
          st_q <= PAIR_POP;
        end
        DRAIN: begin
          if (ns_q != '0) ns_q <= ns_m1;
          else nl_q <= nl_m1;
          st_q <= PAIR_POP;
        end
        EMIT_RD: st_q <= EMIT_CHK;
        EMIT_CHK: begin
          alias_q <= zt ? i_idx : a_rd_q;
          if (zt || pa_rd_q >= tot_q) begin
            prob_q <= {1'b1, {F{1'b0}}};
            st_q   <= EMIT_OUT;
          end else begin
            prob_q <= '0;
            rem_q  <= pa_rd_q;
            quo_q  <= '0;
            bc_q   <= BC_W'(F);
            st_q   <= EMIT_DIV;
          end
        end
        EMIT_DIV: begin
          if (!r2_sub[TOT_W]) begin
            rem_q <= r2_sub[TOT_W-1:0];
            quo_q <= {quo_q[F-2:0], 1'b1};
          end else begin
            rem_q <= r2[TOT_W-1:0];
            quo_q <= {quo_q[F-2:0], 1'b0};
          end
          bc_q <= bc_q - BC_W'(1);
          if (bc_q == BC_W'(1)) st_q <= EMIT_OUT;
        end
        EMIT_OUT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.entry_index <= IDX_OUT_W'(i_q);
            out_q.keep_prob   <= (prob_q[F]) ? PROB_OUT_W'(prob_q)
                                             : PROB_OUT_W'(quo_q);
            out_q.alias_index <= IDX_OUT_W'(alias_q);
            out_q.last_entry  <= is_last;
            out_q.overflowed  <= ovf_q;
            out_q.zero_total  <= zt;
            prob_q            <= '0;
            if (is_last) begin
              st_q <= IDLE;
            end else begin
              i_q  <= i_q + CNT_W'(1);
              st_q <= EMIT_RD;
            end
          end
        end
        default: st_q <= IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == PAIR_POP) |-> ({1'b0, ns_q} + {1'b0, nl_q} <= {1'b0, n_q}))
    else $error("stack depth exceeds entry count");

  a_small_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == PAIR_UPD) |-> (pa_rd_q < tot_q))
    else $error("popped small entry is not below total");

  a_rem_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == EMIT_DIV) |-> (rem_q < tot_q))
    else $error("divider remainder out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == EMIT_DIV) |-> !zt)
    else $error("divide entered with zero total");

endmodule

// ----- tb/alias_table_checker.sv -----
module alias_table_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  atb_pkg::atb_in_t  in_word_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  atb_pkg::atb_out_t out_word_i,
  output int               fail_count_o,
  output int               pending_o
);
  import atb_pkg::*;

  localparam int CAP = MAX_ENTRIES_DEF;

  bit [63:0] weights[CAP];
  int        stored;
  bit [63:0] total;
  bit        dropped;
  atb_out_t  table_q[$];
  int        mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = table_q.size();

  // Build the alias table of the stored weights and queue one entry per weight.
  task automatic build_table();
    bit [63:0] scaled[CAP];
    bit [5:0]  alias_of[CAP];
    int        small_s[CAP];
    int        large_s[CAP];
    int        ns, nl;
    int        s, l;
    bit [63:0] need, prob;
    atb_out_t  e;
    ns = 0;
    nl = 0;
    for (int i = 0; i < stored; i++) begin
      scaled[i]   = weights[i] * stored;
      alias_of[i] = i[5:0];
    end
    if (total != 0) begin
      for (int i = 0; i < stored; i++) begin
        if (scaled[i] < total) begin
          small_s[ns] = i;
          ns++;
        end else begin
          large_s[nl] = i;
          nl++;
        end
      end
      while (ns > 0 && nl > 0) begin
        ns--;
        s = small_s[ns];
        nl--;
        l = large_s[nl];
        need = total - scaled[s];
        alias_of[s] = l[5:0];
        scaled[l] = (scaled[l] >= need) ? scaled[l] - need : 64'd0;
        if (scaled[l] < total) begin
          small_s[ns] = l;
          ns++;
        end else begin
          large_s[nl] = l;
          nl++;
        end
      end
      for (int k = 0; k < ns; k++) scaled[small_s[k]] = total;
      for (int k = 0; k < nl; k++) scaled[large_s[k]] = total;
    end
    for (int i = 0; i < stored; i++) begin
      if (total == 0 || scaled[i] >= total) prob = 64'd1 << PROB_FRAC_BITS_DEF;
      else prob = (scaled[i] << PROB_FRAC_BITS_DEF) / total;
      e.entry_index = i[5:0];
      e.keep_prob   = prob[PROB_OUT_W-1:0];
      e.alias_index = (total == 0) ? i[5:0] : alias_of[i];
      e.last_entry  = (i + 1 == stored);
      e.overflowed  = dropped;
      e.zero_total  = (total == 0);
      table_q.insert(table_q.size(), e);
    end
    stored  = 0;
    total   = 0;
    dropped = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    atb_out_t exp_w;
    if (!rst_ni) begin
      stored     = 0;
      total      = 0;
      dropped    = 0;
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (table_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected word %p", out_word_i);
          mismatches = mismatches + 1;
        end else begin
          exp_w = table_q.pop_front();
          if (exp_w.entry_index != out_word_i.entry_index ||
              exp_w.keep_prob   != out_word_i.keep_prob   ||
              exp_w.alias_index != out_word_i.alias_index ||
              exp_w.last_entry  != out_word_i.last_entry  ||
              exp_w.overflowed  != out_word_i.overflowed  ||
              exp_w.zero_total  != out_word_i.zero_total) begin
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", exp_w, out_word_i);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (stored < CAP) begin
          weights[stored] = in_word_i.weight;
          stored = stored + 1;
          total  = total + in_word_i.weight;
        end else begin
          dropped = 1;
        end
        if (in_word_i.last_weight) build_table();
      end
    end
  end

endmodule

// ----- tb/alias_table_builder_unit_tb.sv -----
module alias_table_builder_unit_tb;
  import atb_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  atb_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_stall_i;
  atb_out_t out_word_o;
  int       fail_count;
  int       pending;
  bit       hold_request;
  bit       steady_recv;

  alias_table_builder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  alias_table_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #(8 * 3000000);
    $display("status: fail");
    $finish;
  end

  // Receiver: random stall before each word, a calm stretch now and then,
  // and one long hold-off when the sender asks for it.
  initial begin
    int gap;
    bit hold_taken;
    hold_taken = 0;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_request && !hold_taken) begin
        hold_taken = 1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      gap = steady_recv ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  int  sent;
  bit  steady_send;

  // Offer one word; hold it until accepted.
  task automatic send_word(input logic [31:0] w, input logic last);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{weight: w, last_weight: last};
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  function automatic logic [31:0] draw_weight(input int style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Send a table of len weights; words past the store capacity get dropped.
  task automatic send_table(input int len, input int style);
    for (int i = 0; i < len; i++) send_word(draw_weight(style), i == len - 1);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    hold_request = 0;
    steady_recv  = 0;
    steady_send  = 0;
    sent         = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single zero, single max, zero total, extremes mixed, small ramps, equal weights, a near-half split.
    send_word(32'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'd0, 1'b0); send_word(32'd0, 1'b0); send_word(32'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0); send_word(32'd0, 1'b0);
    send_word(32'd1, 1'b0); send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'd1, 1'b0); send_word(32'd2, 1'b0); send_word(32'd3, 1'b1);
    send_word(32'd7, 1'b0); send_word(32'd7, 1'b0); send_word(32'd7, 1'b1);
    send_word(32'h8000_0000, 1'b0); send_word(32'h7FFF_FFFF, 1'b1);

    // Sender pause: let every queued entry drain.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);

    // Full store, then overflow with the last flag on a dropped word,
    // with a long receiver hold-off while the next table is offered.
    hold_request = 1;
    send_table(64, 0);
    send_table(5, 1);
    send_table(67, 2);

    while (sent < 350) begin
      steady_send = ($urandom_range(0, 5) == 0);
      steady_recv = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 30) == 0) send_table($urandom_range(60, 66), $urandom_range(0, 3));
      else send_table($urandom_range(1, 8), $urandom_range(0, 3));
    end
    in_valid_i <= 1'b0;
    steady_recv = 0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
